FILE: rtl/tcm_pkg.sv
`timescale 1ns / 1ps
package tcm_pkg;

  localparam int NUM_CH = 3;
  localparam logic [9:0] VOLT_LO = 10'd630;
  localparam logic [9:0] VOLT_HI = 10'd870;
  localparam logic signed [12:0] AMP_LIM = 13'sd3000;
  localparam logic [11:0] TEMP_OPEN = 12'd200;
  localparam logic [11:0] TEMP_SHORT = 12'd4000;

  localparam logic [2:0] CFG_VOLT_NUM = 3'd0;
  localparam logic [2:0] CFG_VOLT_DEN = 3'd1;
  localparam logic [2:0] CFG_CUR_OFS = 3'd2;
  localparam logic [2:0] CFG_CUR_NUM = 3'd3;
  localparam logic [2:0] CFG_CUR_DEN = 3'd4;
  localparam logic [2:0] CFG_STALL = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;      // latch the accepted item
    logic scan_wr;    // write the scan into the windows
    logic acc_clr;    // clear accumulators
    logic acc_en;     // accumulate the sample read last cycle
    logic mean_start; // start mean division for the current channel
    logic conv_start; // start the scaling phase
    logic finish;     // commit held values and load the result register
  } tcm_cmd_t;

  typedef struct packed {
    logic is_scan;
    logic div_done;
    logic conv_done;
  } tcm_sts_t;

endpackage

FILE: rtl/tcm_if.sv
`timescale 1ns / 1ps
interface tcm_in_if #(parameter int SB = 12) ();
  logic          valid;
  logic          ready;
  logic          func;
  logic [31:0]   now_ms;
  logic [SB-1:0] temp_sample;
  logic [SB-1:0] current_sample;
  logic [SB-1:0] voltage_sample;
  modport source (output valid, func, now_ms, temp_sample, current_sample, voltage_sample,
                  input ready);
  modport sink (input valid, func, now_ms, temp_sample, current_sample, voltage_sample,
                output ready);
endinterface

interface tcm_out_if #(parameter int SB = 12) ();
  logic               valid;
  logic               ready;
  logic               ready_res;
  logic               stalled_flag;
  logic               stall_raised;
  logic [15:0]        idle_ms;
  logic [9:0]         pack_decivolts;
  logic               volt_out_of_range;
  logic signed [12:0] pack_deciamps;
  logic               current_over_limit;
  logic [SB-1:0]      temp_count;
  logic               temp_sensor_fault;
  modport source (output valid, ready_res, stalled_flag, stall_raised, idle_ms,
                  pack_decivolts, volt_out_of_range, pack_deciamps, current_over_limit,
                  temp_count, temp_sensor_fault, input ready);
  modport sink (input valid, ready_res, stalled_flag, stall_raised, idle_ms,
                pack_decivolts, volt_out_of_range, pack_deciamps, current_over_limit,
                temp_count, temp_sensor_fault, output ready);
endinterface

FILE: rtl/tcm_divider.sv
`timescale 1ns / 1ps
module tcm_divider #(
  parameter int NW = 48,
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  // Restoring divider, one quotient bit a cycle.
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [DW:0]   trial;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r[DW-1:0], q_r[NW-1]};
    if (start) begin
      q_nxt = num;
      rem_nxt = '0;
      cnt_nxt = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= den;
  end

  assign done = done_r;
  assign quo = q_r;
endmodule

FILE: rtl/tcm_ctrl.sv
`timescale 1ns / 1ps
module tcm_ctrl #(
  parameter int WINDOW_DEPTH = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  logic                 out_busy,
  input  tcm_pkg::tcm_sts_t    sts,
  output tcm_pkg::tcm_cmd_t    cmd,
  output logic [1:0]           ch,
  output logic [$clog2(WINDOW_DEPTH)-1:0] rd_idx,
  output logic                 idle
);
  import tcm_pkg::*;
  localparam int IW = $clog2(WINDOW_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WR   = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_CONV = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_WAIT = 3'd6;

  logic [2:0]    st_r, st_nxt;
  logic [1:0]    ch_r, ch_nxt;
  logic [IW:0]   idx_r, idx_nxt;
  logic          accv_r, accv_nxt;

  always_comb begin
    st_nxt = st_r;
    ch_nxt = ch_r;
    idx_nxt = idx_r;
    accv_nxt = 1'b0;
    cmd = '0;
    cmd.acc_en = accv_r;
    unique case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.start = 1'b1;
          st_nxt = S_WR;
        end
      end
      S_WR: begin
        if (sts.is_scan) begin
          cmd.scan_wr = 1'b1;
          cmd.acc_clr = 1'b1;
          ch_nxt = 2'd0;
          idx_nxt = '0;
          st_nxt = S_RD;
        end else begin
          st_nxt = S_FIN;
        end
      end
      S_RD: begin
        // Issue one window read per cycle; data is accumulated in the next cycle.
        if (idx_r < (IW+1)'(WINDOW_DEPTH)) begin
          accv_nxt = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end else if (!accv_r) begin
          cmd.mean_start = 1'b1;
          st_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          if (ch_r == 2'(NUM_CH - 1)) begin
            cmd.conv_start = 1'b1;
            st_nxt = S_CONV;
          end else begin
            ch_nxt = ch_r + 1'b1;
            idx_nxt = '0;
            cmd.acc_clr = 1'b1;
            st_nxt = S_RD;
          end
        end
      end
      S_CONV: if (sts.conv_done) st_nxt = S_FIN;
      S_FIN: begin
        if (!out_busy) begin
          cmd.finish = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ch_r <= '0;
      idx_r <= '0;
      accv_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ch_r <= ch_nxt;
      idx_r <= idx_nxt;
      accv_r <= accv_nxt;
    end
  end

  assign ch = ch_r;
  assign rd_idx = idx_r[IW-1:0];
  assign idle = (st_r == S_IDLE);

  a_fin_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !out_busy) else $error("finish while result held");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> st_r == S_WR) else $error("start did not advance");
  a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
    ch_r != 2'd3) else $error("channel out of range");
endmodule

FILE: rtl/tcm_datapath.sv
`timescale 1ns / 1ps
module tcm_datapath #(
  parameter int WINDOW_DEPTH = 10,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tcm_pkg::tcm_cmd_t      cmd,
  output tcm_pkg::tcm_sts_t      sts,
  input  logic [1:0]             ch,
  input  logic [$clog2(WINDOW_DEPTH)-1:0] rd_idx,
  input  logic                   func,
  input  logic [31:0]            now_ms,
  input  logic [SAMPLE_BITS-1:0] temp_sample,
  input  logic [SAMPLE_BITS-1:0] current_sample,
  input  logic [SAMPLE_BITS-1:0] voltage_sample,
  input  logic [19:0]            volt_gain_num,
  input  logic [23:0]            volt_gain_den,
  input  logic [11:0]            current_offset,
  input  logic [15:0]            current_gain_num,
  input  logic [15:0]            current_gain_den,
  input  logic [15:0]            stall_limit_ms,
  output logic                   res_ready,
  output logic                   res_stalled,
  output logic                   res_raised,
  output logic [15:0]            res_idle,
  output logic [9:0]             res_dv,
  output logic                   res_vflag,
  output logic signed [12:0]     res_da,
  output logic                   res_cflag,
  output logic [SAMPLE_BITS-1:0] res_tc,
  output logic                   res_tflag
);
  import tcm_pkg::*;
  localparam int IW = $clog2(WINDOW_DEPTH);
  localparam int SW = SAMPLE_BITS + $clog2(WINDOW_DEPTH + 1);
  localparam int NW = 48;
  localparam int SB = SAMPLE_BITS;
  // Compare and offset width: wide enough for a sample and the 12-bit constants.
  localparam int TW = (SB > 12) ? SB : 12;

  // Per-channel windows; each is one slot register per entry in flip-flops.
  logic [SB-1:0] win_r [NUM_CH][WINDOW_DEPTH];
  logic [IW-1:0] slot_r;
  logic [IW:0]   fill_r;
  logic [31:0]   last_r;
  logic          seeded_r, stall_r;
  logic [9:0]    hdv_r;
  logic signed [12:0] hda_r;
  logic [SB-1:0] htc_r;
  logic [2:0]    hfl_r;
  logic          func_r;
  logic [31:0]   now_r;
  logic [SB-1:0] smp_r [NUM_CH];
  logic [SB-1:0] mean_r [NUM_CH];

  logic [SW-1:0] sum_r;
  logic [SB-1:0] lo_r, hi_r, rd_r;
  logic [IW:0]   cnt_r;

  // Shared divider
  logic          div_start, div_done;
  logic [NW-1:0] div_num, div_q;
  logic [23:0]   div_den;
  tcm_divider #(.NW(NW), .DW(24)) u_div (
    .clk, .rst_n, .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_q));

  // Scaling phases: 0 mean, 1 voltage, 2 current
  logic [1:0]    ph_r;
  logic [1:0]    cst_r;
  logic [NW-1:0] prod_r;
  logic          cneg_r;
  logic [9:0]    dv_r;
  logic          vfl_r, cfl_r, conv_done_r;
  logic signed [12:0] da_r;

  logic [23:0]   vden, cden;
  logic [IW:0]   n_eff;
  logic [SW-1:0] tsum;
  logic signed [TW+1:0] delta;
  logic [TW:0]   mag;
  logic          tflag;

  assign vden = (volt_gain_den == '0) ? 24'd1 : volt_gain_den;
  assign cden = (current_gain_den == '0) ? 24'd1 : {8'd0, current_gain_den};
  assign n_eff = (fill_r >= (IW+1)'(3)) ? fill_r - (IW+1)'(2) : fill_r;
  assign tsum = (fill_r >= (IW+1)'(3)) ? sum_r - SW'(lo_r) - SW'(hi_r) : sum_r;
  assign delta = $signed((TW+2)'(mean_r[1])) - $signed((TW+2)'(current_offset));
  assign mag = delta[TW+1] ? (TW+1)'(-delta) : (TW+1)'(delta);
  assign tflag = (TW'(mean_r[0]) < TW'(TEMP_OPEN)) || (TW'(mean_r[0]) > TW'(TEMP_SHORT));

  always_comb begin
    div_start = 1'b0;
    div_num = '0;
    div_den = '0;
    if (cmd.mean_start) begin
      div_start = 1'b1;
      div_num = NW'(tsum) + NW'(n_eff >> 1);
      div_den = 24'(n_eff);
    end else if (cst_r == 2'd1) begin
      div_start = 1'b1;
      if (ph_r == 2'd1) begin
        div_num = prod_r + NW'(vden >> 1);
        div_den = vden;
      end else begin
        div_num = prod_r + NW'(cden >> 1);
        div_den = cden;
      end
    end
  end

  assign sts.is_scan = func_r;
  assign sts.div_done = div_done && ph_r == 2'd0;
  assign sts.conv_done = conv_done_r;

  logic [IW:0] fill_nxt;
  logic [31:0] idle_t;
  always_comb begin
    fill_nxt = (fill_r < (IW+1)'(WINDOW_DEPTH)) ? fill_r + 1'b1 : fill_r;
    idle_t = now_r - (seeded_r ? last_r : now_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      fill_r <= '0;
      last_r <= '0;
      seeded_r <= 1'b0;
      stall_r <= 1'b0;
      hdv_r <= VOLT_LO;
      hda_r <= '0;
      htc_r <= '0;
      hfl_r <= '0;
      ph_r <= '0;
      cst_r <= '0;
      conv_done_r <= 1'b0;
    end else begin
      conv_done_r <= 1'b0;
      if (cmd.scan_wr) begin
        slot_r <= (slot_r == IW'(WINDOW_DEPTH - 1)) ? '0 : slot_r + 1'b1;
        fill_r <= fill_nxt;
      end
      if (cmd.conv_start) begin
        ph_r <= 2'd1;
        cst_r <= 2'd0;
      end else if (ph_r != 2'd0) begin
        case (cst_r)
          2'd0: cst_r <= 2'd1;
          2'd1: cst_r <= 2'd2;
          default: begin
            if (div_done) begin
              cst_r <= 2'd0;
              if (ph_r == 2'd1) ph_r <= 2'd2;
              else begin
                ph_r <= 2'd0;
                conv_done_r <= 1'b1;
              end
            end
          end
        endcase
      end
      if (cmd.finish) begin
        seeded_r <= 1'b1;
        if (func_r) begin
          last_r <= now_r;
          stall_r <= 1'b0;
          hdv_r <= dv_r;
          hda_r <= da_r;
          htc_r <= mean_r[0];
          hfl_r <= {tflag, cfl_r, vfl_r};
        end else begin
          if (!seeded_r) last_r <= now_r;
          if (!stall_r && idle_t >= {16'd0, stall_limit_ms}) stall_r <= 1'b1;
        end
      end
    end
    if (cmd.start) begin
      func_r <= func;
      now_r <= now_ms;
      smp_r[0] <= temp_sample;
      smp_r[1] <= current_sample;
      smp_r[2] <= voltage_sample;
    end
    if (cmd.scan_wr) begin
      for (int c = 0; c < NUM_CH; c++) win_r[c][slot_r] <= smp_r[c];
    end
    rd_r <= win_r[ch][rd_idx];
    if (cmd.acc_clr) begin
      sum_r <= '0;
      lo_r <= '1;
      hi_r <= '0;
      cnt_r <= '0;
    end else if (cmd.acc_en && cnt_r < fill_r) begin
      sum_r <= sum_r + SW'(rd_r);
      if (rd_r < lo_r) lo_r <= rd_r;
      if (rd_r > hi_r) hi_r <= rd_r;
      cnt_r <= cnt_r + 1'b1;
    end else if (cmd.acc_en) begin
      cnt_r <= cnt_r;
    end
    if (sts.div_done) mean_r[ch] <= div_q[SB-1:0];
    // Product stage, one multiplier per phase
    if (ph_r != 2'd0 && cst_r == 2'd0) begin
      if (ph_r == 2'd1) prod_r <= NW'(mean_r[2]) * NW'(volt_gain_num);
      else begin
        prod_r <= NW'(mag) * NW'(current_gain_num);
        cneg_r <= delta[TW+1];
      end
    end
    if (div_done && ph_r == 2'd1) begin
      if (div_q < NW'(VOLT_LO)) begin
        dv_r <= VOLT_LO;
        vfl_r <= 1'b1;
      end else if (div_q > NW'(VOLT_HI)) begin
        dv_r <= VOLT_HI;
        vfl_r <= 1'b1;
      end else begin
        dv_r <= div_q[9:0];
        vfl_r <= 1'b0;
      end
    end
    if (div_done && ph_r == 2'd2) begin
      if (div_q > NW'(AMP_LIM)) begin
        da_r <= cneg_r ? -AMP_LIM : AMP_LIM;
        cfl_r <= 1'b1;
      end else begin
        da_r <= cneg_r ? -$signed(div_q[12:0]) : $signed(div_q[12:0]);
        cfl_r <= 1'b0;
      end
    end
  end

  // Result fields; the top level registers them.
  logic stall_new;
  assign stall_new = !func_r && !stall_r && idle_t >= {16'd0, stall_limit_ms};
  assign res_stalled = func_r ? 1'b0 : (stall_r || stall_new);
  assign res_raised = stall_new;
  assign res_idle = stall_new ? ((idle_t > 32'hFFFF) ? 16'hFFFF : idle_t[15:0]) : 16'd0;
  assign res_ready = ((func_r ? fill_r : fill_r) >= (IW+1)'(WINDOW_DEPTH)) && !res_stalled;
  assign res_dv = func_r ? dv_r : hdv_r;
  assign res_vflag = func_r ? vfl_r : hfl_r[0];
  assign res_da = func_r ? da_r : hda_r;
  assign res_cflag = func_r ? cfl_r : hfl_r[1];
  assign res_tc = func_r ? mean_r[0] : htc_r;
  assign res_tflag = func_r ? tflag : hfl_r[2];

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= (IW+1)'(WINDOW_DEPTH)) else $error("fill count overflow");
  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r < IW'(WINDOW_DEPTH)) else $error("write slot overflow");
  a_dv_range: assert property (@(posedge clk) disable iff (!rst_n)
    hdv_r >= VOLT_LO && hdv_r <= VOLT_HI) else $error("held voltage out of range");
endmodule

FILE: rtl/three_channel_trimmed_mean_conditioner.sv
`timescale 1ns / 1ps
// A tick without a scan passes from acceptance through the write check to the result load;
// a scan averages each channel's window in turn, then scales voltage and current.
// Throughput: one item at a time, taken the cycle after the result is loaded, set by the
// shared bit-serial divider (three means and two scalings per scan) and the one-read-a-cycle
// window walk; a held result stalls it.
// Reset: synchronous active-low rst_n clears control, windows count and held values.
module three_channel_trimmed_mean_conditioner #(
  parameter int WINDOW_DEPTH = 10,
  parameter int SAMPLE_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  tcm_in_if.sink      in_ch,
  tcm_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import tcm_pkg::*;
  localparam int IW = $clog2(WINDOW_DEPTH);

  // Configuration registers; the user writes them only while the block is idle (not enforced here).
  logic [19:0] vnum_r;
  logic [23:0] vden_r;
  logic [11:0] cofs_r;
  logic [15:0] cnum_r, cden_r, stl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vnum_r <= 20'd228554;
      vden_r <= 24'd1000000;
      cofs_r <= 12'd2048;
      cnum_r <= 16'd3000;
      cden_r <= 16'd2048;
      stl_r <= 16'd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VOLT_NUM: vnum_r <= cfg_data[19:0];
        CFG_VOLT_DEN: vden_r <= cfg_data;
        CFG_CUR_OFS: cofs_r <= cfg_data[11:0];
        CFG_CUR_NUM: cnum_r <= cfg_data[15:0];
        CFG_CUR_DEN: cden_r <= cfg_data[15:0];
        CFG_STALL: stl_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  tcm_cmd_t cmd;
  tcm_sts_t sts;
  logic [1:0] ch;
  logic [IW-1:0] rd_idx;
  logic idle, out_v_r;

  // The result register lets a finished item wait while the controller is idle again.
  assign in_ch.ready = idle;

  tcm_ctrl #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_ctrl (
    .clk, .rst_n, .in_fire(in_ch.valid && in_ch.ready),
    .out_busy(out_v_r && !out_ch.ready), .sts, .cmd, .ch, .rd_idx, .idle);

  logic r_ready, r_stalled, r_raised, r_vflag, r_cflag, r_tflag;
  logic [15:0] r_idle;
  logic [9:0] r_dv;
  logic signed [12:0] r_da;
  logic [SAMPLE_BITS-1:0] r_tc;

  tcm_datapath #(.WINDOW_DEPTH(WINDOW_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .ch, .rd_idx,
    .func(in_ch.func), .now_ms(in_ch.now_ms), .temp_sample(in_ch.temp_sample),
    .current_sample(in_ch.current_sample), .voltage_sample(in_ch.voltage_sample),
    .volt_gain_num(vnum_r), .volt_gain_den(vden_r), .current_offset(cofs_r),
    .current_gain_num(cnum_r), .current_gain_den(cden_r), .stall_limit_ms(stl_r),
    .res_ready(r_ready), .res_stalled(r_stalled), .res_raised(r_raised),
    .res_idle(r_idle), .res_dv(r_dv), .res_vflag(r_vflag), .res_da(r_da),
    .res_cflag(r_cflag), .res_tc(r_tc), .res_tflag(r_tflag));

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (cmd.finish) out_v_r <= 1'b1;
    else if (out_ch.ready) out_v_r <= 1'b0;
    if (cmd.finish) begin
      out_ch.ready_res <= r_ready;
      out_ch.stalled_flag <= r_stalled;
      out_ch.stall_raised <= r_raised;
      out_ch.idle_ms <= r_idle;
      out_ch.pack_decivolts <= r_dv;
      out_ch.volt_out_of_range <= r_vflag;
      out_ch.pack_deciamps <= r_da;
      out_ch.current_over_limit <= r_cflag;
      out_ch.temp_count <= r_tc;
      out_ch.temp_sensor_fault <= r_tflag;
    end
  end
  assign out_ch.valid = out_v_r;

  a_one_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ch.ready) |=> out_v_r) else $error("result dropped");
  a_raise_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_ch.stall_raised) |-> out_ch.stalled_flag) else $error("raise without stall");
  a_ready_not_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_ch.ready_res) |-> !out_ch.stalled_flag) else $error("ready while stalled");
endmodule
